>>> sv/tcv_pkg.sv
// ----------------------------------------------------------------------------
// tcv_pkg
// Shared types, codes and constants for the context message validator.
// ----------------------------------------------------------------------------
package tcv_pkg;

   // framing
   localparam int unsigned MAGIC_BYTES = 5;               // 1..8
   localparam int unsigned HDR_LEN     = MAGIC_BYTES + 4; // magic, version, kind, count
   localparam int unsigned ENTRY_HDR   = 5;               // id(2), flags, length(2)

   localparam logic [15:0] ID_TOP_MASK  = 16'h8000;
   localparam logic [15:0] ID_REST_MASK = 16'h7fff;

   // result status codes
   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_TRUNC    = 4'd1,
      ST_MAGIC    = 4'd2,
      ST_VERSION  = 4'd3,
      ST_KIND     = 4'd4,
      ST_CAPACITY = 4'd5,
      ST_ZERO_ID  = 4'd6,
      ST_ORDER    = 4'd7,
      ST_CRIT     = 4'd8,
      ST_FLAGS    = 4'd9,
      ST_TRAILING = 4'd10
   } status_type;

   // message parser phase
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_ENTRY  = 3'd2,
      PH_VALUE  = 3'd3
   } phase_type;

   // input item kind
   typedef enum logic {
      IK_BEGIN = 1'b0,
      IK_DATA  = 1'b1
   } in_kind_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_EXPECTED_VERSION = 3'd0,
      CSR_KIND_LOW         = 3'd1,
      CSR_KIND_HIGH        = 3'd2,
      CSR_CRITICAL_KIND    = 3'd3,
      CSR_CAPTURE_ENABLE   = 3'd4,
      CSR_ENTRY_CAPACITY   = 3'd5
   } csr_index_type;

   // configuration reset values
   localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd1;
   localparam logic [7:0]  RST_KIND_LOW         = 8'd1;
   localparam logic [7:0]  RST_KIND_HIGH        = 8'd3;
   localparam logic [7:0]  RST_CRITICAL_KIND    = 8'd2;
   localparam logic        RST_CAPTURE_ENABLE   = 1'b1;
   localparam logic [15:0] RST_ENTRY_CAPACITY   = 16'd16;

   // one result item
   typedef struct packed {
      logic        is_final;
      status_type  status;
      logic [7:0]  message_kind;
      logic [15:0] num_entries;
      logic [15:0] entry_id;
      logic [31:0] value_offset;
      logic [15:0] value_length;
      logic        last;
   } result_type;

   // expected magic byte at a header position; positions past the fifth are zero
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h5a; // Z
         3'd1:    b = 8'h4b; // K
         3'd2:    b = 8'h43; // C
         3'd3:    b = 8'h54; // T
         3'd4:    b = 8'h58; // X
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> sv/tlv_context_validator_top.sv
// ----------------------------------------------------------------------------
// tlv_context_validator_top
// Streaming validator for one framed context message.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries items: tuser 0 is a begin transfer with the total message
//    length, tuser 1 a data transfer with the next message byte.
//  - rsp_* returns entry records (tuser 0, in capture mode) and one final
//    status per message (tuser 1). tlast marks the last result of one input.
//  - csr_* writes the six configuration registers, one per clock, no wait.
//  - Every item is parsed in the cycle it is taken; its results (at most two)
//    are written into the result queue. One item is accepted per cycle
//    while req_tready is high; results go into a four-deep queue, and
//    req_tready is high while it has room for two more, so a stalled receiver
//    holds off the sender once three results wait; nothing is lost or dropped.
//  - A begin transfer drops any message in progress. Data after a final
//    status, or before any begin, is swallowed without a result.
//  - Synchronous reset returns the parser to idle, empties the queue and
//    loads the configuration reset values.
// ----------------------------------------------------------------------------
module tlv_context_validator_top (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,  // [31:0] total_len, [39:32] data_byte
   input  logic         req_tuser,  // [0] kind
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // [3:0] status, [11:4] message_kind,
                                    // [27:12] num_entries, [43:28] entry_id,
                                    // [75:44] value_offset, [91:76] value_length
   output logic         rsp_tuser,  // [0] is_final
   output logic         rsp_tlast,
   // configuration write port
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [7:0]  expected_version_ff;
   logic [7:0]  kind_low_ff;
   logic [7:0]  kind_high_ff;
   logic [7:0]  critical_kind_ff;
   logic        capture_enable_ff;
   logic [15:0] entry_capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= tcv_pkg::RST_EXPECTED_VERSION;
         kind_low_ff         <= tcv_pkg::RST_KIND_LOW;
         kind_high_ff        <= tcv_pkg::RST_KIND_HIGH;
         critical_kind_ff    <= tcv_pkg::RST_CRITICAL_KIND;
         capture_enable_ff   <= tcv_pkg::RST_CAPTURE_ENABLE;
         entry_capacity_ff   <= tcv_pkg::RST_ENTRY_CAPACITY;
      end else if (csr_we) begin
         case (csr_index)
            tcv_pkg::CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata[7:0];
            tcv_pkg::CSR_KIND_LOW:         kind_low_ff         <= csr_wdata[7:0];
            tcv_pkg::CSR_KIND_HIGH:        kind_high_ff        <= csr_wdata[7:0];
            tcv_pkg::CSR_CRITICAL_KIND:    critical_kind_ff    <= csr_wdata[7:0];
            tcv_pkg::CSR_CAPTURE_ENABLE:   capture_enable_ff   <= csr_wdata[0];
            tcv_pkg::CSR_ENTRY_CAPACITY:   entry_capacity_ff   <= csr_wdata;
            default: ;  // writes beyond the register list are ignored
         endcase
      end
   end

   // ---------------- parser state ----------------
   tcv_pkg::phase_type phase_ff, phase_in;
   logic [31:0] msg_length_ff, msg_length_in;
   logic [31:0] byte_offset_ff, byte_offset_in;
   logic [2:0]  field_index_ff, field_index_in;
   logic [15:0] declared_ff, declared_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] prev_id_ff, prev_id_in;
   logic [15:0] cur_id_ff, cur_id_in;
   logic [15:0] cur_vlen_ff, cur_vlen_in;
   logic [15:0] vleft_ff, vleft_in;
   logic [7:0]  msg_kind_ff, msg_kind_in;

   logic        req_fire;
   logic [7:0]  in_byte;
   logic [31:0] in_len;
   logic [31:0] off_inc;      // byte offset after this byte
   logic [15:0] new_id;
   logic [15:0] new_vlen;
   logic [15:0] vleft_dec;
   logic [32:0] need_len;     // 5 * count + header, against the total length
   logic [31:0] room;         // bytes left after this byte

   // outcome of one item
   logic                 fin;       // final status produced
   tcv_pkg::status_type  fin_st;
   logic                 rec;       // entry record produced
   logic                 ne_req;    // next entry header due
   logic [15:0]          ne_seen;

   assign req_fire  = req_tvalid && req_tready;
   assign in_len    = req_tdata[31:0];
   assign in_byte   = req_tdata[39:32];
   assign off_inc   = byte_offset_ff + 32'd1;
   assign room      = msg_length_ff - off_inc;
   assign new_id    = {in_byte, cur_id_ff[7:0]};
   assign new_vlen  = {in_byte, cur_vlen_ff[7:0]};
   assign vleft_dec = vleft_ff - 16'd1;
   assign need_len  = {15'd0, in_byte, declared_ff[7:0], 2'b00}
                    + {17'd0, in_byte, declared_ff[7:0]}
                    + 33'(tcv_pkg::HDR_LEN);

   always_comb begin
      phase_in       = phase_ff;
      msg_length_in  = msg_length_ff;
      byte_offset_in = byte_offset_ff;
      field_index_in = field_index_ff;
      declared_in    = declared_ff;
      seen_in        = seen_ff;
      prev_id_in     = prev_id_ff;
      cur_id_in      = cur_id_ff;
      cur_vlen_in    = cur_vlen_ff;
      vleft_in       = vleft_ff;
      msg_kind_in    = msg_kind_ff;
      fin            = 1'b0;
      fin_st         = tcv_pkg::ST_OK;
      rec            = 1'b0;
      ne_req         = 1'b0;
      ne_seen        = seen_ff;

      if (req_fire) begin
         if (req_tuser == tcv_pkg::IK_BEGIN) begin
            // new message: whatever was in progress is dropped
            phase_in       = tcv_pkg::PH_HEADER;
            msg_length_in  = in_len;
            byte_offset_in = '0;
            field_index_in = '0;
            declared_in    = '0;
            seen_in        = '0;
            prev_id_in     = '0;
            cur_id_in      = '0;
            cur_vlen_in    = '0;
            vleft_in       = '0;
            msg_kind_in    = '0;
            if (in_len < 32'(tcv_pkg::HDR_LEN)) begin
               fin    = 1'b1;
               fin_st = tcv_pkg::ST_TRUNC;
            end
         end else if (phase_ff != tcv_pkg::PH_IDLE) begin
            byte_offset_in = off_inc;
            case (phase_ff)
               tcv_pkg::PH_HEADER: begin
                  if (byte_offset_ff < 32'(tcv_pkg::MAGIC_BYTES)) begin
                     if (in_byte != tcv_pkg::magic_byte(byte_offset_ff[2:0])) begin
                        fin    = 1'b1;
                        fin_st = tcv_pkg::ST_MAGIC;
                     end
                  end else if (byte_offset_ff == 32'(tcv_pkg::MAGIC_BYTES)) begin
                     if (in_byte != expected_version_ff) begin
                        fin    = 1'b1;
                        fin_st = tcv_pkg::ST_VERSION;
                     end
                  end else if (byte_offset_ff == 32'(tcv_pkg::MAGIC_BYTES + 1)) begin
                     if (in_byte < kind_low_ff || in_byte > kind_high_ff) begin
                        fin    = 1'b1;
                        fin_st = tcv_pkg::ST_KIND;
                     end else begin
                        msg_kind_in = in_byte;
                     end
                  end else if (byte_offset_ff == 32'(tcv_pkg::MAGIC_BYTES + 2)) begin
                     declared_in = {8'd0, in_byte};
                  end else begin
                     // count > (len - hdr) / 5  is the same as  5 * count + hdr > len
                     declared_in = {in_byte, declared_ff[7:0]};
                     if (need_len > {1'b0, msg_length_ff}) begin
                        fin    = 1'b1;
                        fin_st = tcv_pkg::ST_TRUNC;
                     end else if (capture_enable_ff && declared_in > entry_capacity_ff) begin
                        fin    = 1'b1;
                        fin_st = tcv_pkg::ST_CAPACITY;
                     end else begin
                        ne_req  = 1'b1;
                        ne_seen = seen_ff;
                     end
                  end
               end
               tcv_pkg::PH_ENTRY: begin
                  case (field_index_ff)
                     3'd0: begin
                        cur_id_in      = {8'd0, in_byte};
                        field_index_in = field_index_ff + 3'd1;
                     end
                     3'd1: begin
                        cur_id_in = new_id;
                        if (new_id == 16'd0) begin
                           fin    = 1'b1;
                           fin_st = tcv_pkg::ST_ZERO_ID;
                        end else if (seen_ff != 16'd0 && new_id <= prev_id_ff) begin
                           fin    = 1'b1;
                           fin_st = tcv_pkg::ST_ORDER;
                        end else if (msg_kind_ff == critical_kind_ff &&
                                     ((new_id & tcv_pkg::ID_TOP_MASK) == 16'd0 ||
                                      (new_id & tcv_pkg::ID_REST_MASK) == 16'd0)) begin
                           fin    = 1'b1;
                           fin_st = tcv_pkg::ST_CRIT;
                        end else begin
                           field_index_in = field_index_ff + 3'd1;
                        end
                     end
                     3'd2: begin
                        if (in_byte != 8'd0) begin
                           fin    = 1'b1;
                           fin_st = tcv_pkg::ST_FLAGS;
                        end else begin
                           field_index_in = field_index_ff + 3'd1;
                        end
                     end
                     3'd3: begin
                        cur_vlen_in    = {8'd0, in_byte};
                        field_index_in = field_index_ff + 3'd1;
                     end
                     default: begin
                        cur_vlen_in = new_vlen;
                        if ({16'd0, new_vlen} > room) begin
                           fin    = 1'b1;
                           fin_st = tcv_pkg::ST_TRUNC;
                        end else begin
                           rec        = capture_enable_ff;
                           seen_in    = seen_ff + 16'd1;
                           prev_id_in = cur_id_ff;
                           if (new_vlen == 16'd0) begin
                              ne_req  = 1'b1;
                              ne_seen = seen_ff + 16'd1;
                           end else begin
                              vleft_in = new_vlen;
                              phase_in = tcv_pkg::PH_VALUE;
                           end
                        end
                     end
                  endcase
               end
               default: begin
                  // value bytes are skipped, only counted
                  vleft_in = vleft_dec;
                  if (vleft_dec == 16'd0) begin
                     ne_req  = 1'b1;
                     ne_seen = seen_ff;
                  end
               end
            endcase

            // next entry header, or end of message
            if (ne_req) begin
               if (ne_seen >= declared_in) begin
                  fin    = 1'b1;
                  fin_st = (off_inc != msg_length_ff) ? tcv_pkg::ST_TRAILING
                                                      : tcv_pkg::ST_OK;
               end else if (room < 32'(tcv_pkg::ENTRY_HDR)) begin
                  fin    = 1'b1;
                  fin_st = tcv_pkg::ST_TRUNC;
               end else begin
                  phase_in       = tcv_pkg::PH_ENTRY;
                  field_index_in = '0;
               end
            end
         end
         if (fin) begin
            phase_in = tcv_pkg::PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tcv_pkg::PH_IDLE;
         msg_length_ff  <= '0;
         byte_offset_ff <= '0;
         field_index_ff <= '0;
         declared_ff    <= '0;
         seen_ff        <= '0;
         prev_id_ff     <= '0;
         cur_id_ff      <= '0;
         cur_vlen_ff    <= '0;
         vleft_ff       <= '0;
         msg_kind_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         msg_length_ff  <= msg_length_in;
         byte_offset_ff <= byte_offset_in;
         field_index_ff <= field_index_in;
         declared_ff    <= declared_in;
         seen_ff        <= seen_in;
         prev_id_ff     <= prev_id_in;
         cur_id_ff      <= cur_id_in;
         cur_vlen_ff    <= cur_vlen_in;
         vleft_ff       <= vleft_in;
         msg_kind_ff    <= msg_kind_in;
      end
   end

   // ---------------- result assembly ----------------
   tcv_pkg::result_type rec_res, fin_res, res0, res1;
   logic [1:0] n_res;

   always_comb begin
      rec_res              = '0;
      rec_res.is_final     = 1'b0;
      rec_res.status       = tcv_pkg::ST_OK;
      rec_res.entry_id     = cur_id_ff;
      rec_res.value_offset = off_inc;
      rec_res.value_length = new_vlen;
      rec_res.last         = !fin;

      fin_res          = '0;
      fin_res.is_final = 1'b1;
      fin_res.status   = fin_st;
      fin_res.last     = 1'b1;
      if (fin_st == tcv_pkg::ST_OK) begin
         fin_res.message_kind = msg_kind_in;
         fin_res.num_entries  = declared_in;
      end

      res0  = rec ? rec_res : fin_res;
      res1  = fin_res;
      n_res = {1'b0, rec} + {1'b0, fin};
   end

   // ---------------- result queue (four deep) ----------------
   tcv_pkg::result_type q_mem [4];
   logic [1:0] q_head_ff, q_head_in;
   logic [1:0] q_tail_ff, q_tail_in;
   logic [2:0] q_count_ff, q_count_in;
   logic       rsp_fire;
   logic [1:0] n_push;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign n_push     = req_fire ? n_res : 2'd0;
   assign req_tready = (q_count_ff <= 3'd2);   // room for a worst-case pair
   assign rsp_tvalid = (q_count_ff != 3'd0);

   always_comb begin
      q_head_in  = q_head_ff + {1'b0, rsp_fire};
      q_tail_in  = q_tail_ff + n_push;
      q_count_in = q_count_ff + {1'b0, n_push} - {2'b00, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff  <= '0;
         q_tail_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         q_head_ff  <= q_head_in;
         q_tail_ff  <= q_tail_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_mem[q_tail_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         q_mem[q_tail_ff + 2'd1] <= res1;
      end
   end

   // ---------------- result channel ----------------
   tcv_pkg::result_type q_out;
   assign q_out = q_mem[q_head_ff];

   assign rsp_tdata = {4'd0,
                       q_out.value_length,
                       q_out.value_offset,
                       q_out.entry_id,
                       q_out.num_entries,
                       q_out.message_kind,
                       q_out.status};
   assign rsp_tuser = q_out.is_final;
   assign rsp_tlast = q_out.last;

endmodule

>>> tb/tlv_context_validator_top_test.sv
// ----------------------------------------------------------------------------
// tlv_context_validator_top_test
// Self-checking bench for the context message validator: streams framed
// messages (clean, damaged, cut short and noise) through the request channel
// under bursty traffic and receiver back-pressure. Each result is compared
// field by field against a built-in parser model.
// ----------------------------------------------------------------------------
module tlv_context_validator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int DRAIN_CYCLES    = 8;   // parse cycle + result queue slack

   // magic bytes Z K C T X from the lowest byte up, zero past the fifth
   localparam logic [63:0] MAGIC_REF = 64'h0000_0058_5443_4b5a;

   // one input transfer as the bench sees it
   typedef struct {
      tcv_pkg::in_kind_type kind;
      logic [31:0]          total_len;
      logic [7:0]           data_byte;
   } msg_item_type;

   // ------------------------------------------------------------------------
   // DUT ports, every input known from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [31:0] total_len, [39:32] data_byte
   logic        req_tuser  = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // [3:0] status, [11:4] message_kind,
                                   // [27:12] num_entries, [43:28] entry_id,
                                   // [75:44] value_offset, [91:76] value_length
   logic        rsp_tuser;         // [0] is_final
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   tlv_context_validator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tlv_context_validator_top verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   msg_item_type        item_backlog [$];     // transfers still to be offered
   tcv_pkg::result_type expected_results [$]; // predicted results, oldest first
   tcv_pkg::result_type step_results [$];     // results of the transfer being parsed
   int                  mismatches = 0;

   // shadow of the configuration registers
   logic [7:0]  cfg_version   = tcv_pkg::RST_EXPECTED_VERSION;
   logic [7:0]  cfg_kind_low  = tcv_pkg::RST_KIND_LOW;
   logic [7:0]  cfg_kind_high = tcv_pkg::RST_KIND_HIGH;
   logic [7:0]  cfg_critical  = tcv_pkg::RST_CRITICAL_KIND;
   logic        cfg_capture   = tcv_pkg::RST_CAPTURE_ENABLE;
   logic [15:0] cfg_capacity  = tcv_pkg::RST_ENTRY_CAPACITY;

   // parser model state
   tcv_pkg::phase_type parse_phase = tcv_pkg::PH_IDLE;
   logic [31:0] msg_len      = '0;
   logic [31:0] byte_pos     = '0;
   logic [2:0]  field_pos    = '0;
   logic [15:0] declared_cnt = '0;
   logic [15:0] seen_cnt     = '0;
   logic [15:0] prev_id      = '0;
   logic [15:0] cur_id       = '0;
   logic [7:0]  cur_flags    = '0;
   logic [15:0] cur_vlen     = '0;
   logic [15:0] value_left   = '0;
   logic [7:0]  msg_kind_q   = '0;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   task automatic push_result(input logic fin, input tcv_pkg::status_type st,
                              input logic [7:0] mk,
                              input logic [15:0] cnt, input logic [15:0] id,
                              input logic [31:0] off, input logic [15:0] vl);
      tcv_pkg::result_type r;
      r.is_final     = fin;
      r.status       = st;
      r.message_kind = mk;
      r.num_entries  = cnt;
      r.entry_id     = id;
      r.value_offset = off;
      r.value_length = vl;
      r.last         = 1'b0;
      if (step_results.size() < 2)
         step_results.push_back(r);
   endtask

   // final status ends the message; only ok carries kind and count
   task automatic close_message(input tcv_pkg::status_type st);
      if (st == tcv_pkg::ST_OK)
         push_result(1'b1, tcv_pkg::ST_OK, msg_kind_q, declared_cnt, '0, '0, '0);
      else
         push_result(1'b1, st, '0, '0, '0, '0, '0);
      parse_phase = tcv_pkg::PH_IDLE;
   endtask

   // after the header or an entry: finish, run out of room, or next entry header
   task automatic advance_entry();
      if (seen_cnt >= declared_cnt)
         close_message((byte_pos != msg_len) ? tcv_pkg::ST_TRAILING : tcv_pkg::ST_OK);
      else if (msg_len - byte_pos < tcv_pkg::ENTRY_HDR)
         close_message(tcv_pkg::ST_TRUNC);
      else begin
         parse_phase = tcv_pkg::PH_ENTRY;
         field_pos   = '0;
      end
   endtask

   task automatic predict_item(input tcv_pkg::in_kind_type kind, input logic [31:0] len,
                               input logic [7:0] b);
      logic [31:0] pos;
      step_results = {};
      if (kind == tcv_pkg::IK_BEGIN) begin
         // a begin always restarts, dropping anything in progress silently
         msg_len      = len;
         byte_pos     = '0;
         field_pos    = '0;
         declared_cnt = '0;
         seen_cnt     = '0;
         prev_id      = '0;
         cur_id       = '0;
         cur_flags    = '0;
         cur_vlen     = '0;
         value_left   = '0;
         msg_kind_q   = '0;
         parse_phase  = tcv_pkg::PH_HEADER;
         if (msg_len < tcv_pkg::HDR_LEN)
            close_message(tcv_pkg::ST_TRUNC);
      end else if (parse_phase != tcv_pkg::PH_IDLE) begin
         pos      = byte_pos;
         byte_pos = byte_pos + 1;
         case (parse_phase)
            tcv_pkg::PH_HEADER: begin
               if (pos < tcv_pkg::MAGIC_BYTES) begin
                  if (b != MAGIC_REF[8*pos[2:0] +: 8])
                     close_message(tcv_pkg::ST_MAGIC);
               end else if (pos == tcv_pkg::MAGIC_BYTES) begin
                  if (b != cfg_version)
                     close_message(tcv_pkg::ST_VERSION);
               end else if (pos == tcv_pkg::MAGIC_BYTES + 1) begin
                  if (b < cfg_kind_low || b > cfg_kind_high)
                     close_message(tcv_pkg::ST_KIND);
                  else
                     msg_kind_q = b;
               end else if (pos == tcv_pkg::MAGIC_BYTES + 2) begin
                  declared_cnt = {8'h00, b};
               end else begin
                  declared_cnt[15:8] = b;
                  if (32'(declared_cnt) > (msg_len - tcv_pkg::HDR_LEN) / tcv_pkg::ENTRY_HDR)
                     close_message(tcv_pkg::ST_TRUNC);
                  else if (cfg_capture && declared_cnt > cfg_capacity)
                     close_message(tcv_pkg::ST_CAPACITY);
                  else
                     advance_entry();
               end
            end
            tcv_pkg::PH_ENTRY: begin
               case (field_pos)
                  3'd0: begin
                     cur_id    = {8'h00, b};
                     field_pos = field_pos + 1;
                  end
                  3'd1: begin
                     cur_id[15:8] = b;
                     field_pos    = field_pos + 1;
                     if (cur_id == 16'h0000)
                        close_message(tcv_pkg::ST_ZERO_ID);
                     else if (seen_cnt != 0 && cur_id <= prev_id)
                        close_message(tcv_pkg::ST_ORDER);
                     else if (msg_kind_q == cfg_critical &&
                              ((cur_id & tcv_pkg::ID_TOP_MASK) == 0 ||
                               (cur_id & tcv_pkg::ID_REST_MASK) == 0))
                        close_message(tcv_pkg::ST_CRIT);
                  end
                  3'd2: begin
                     cur_flags = b;
                     field_pos = field_pos + 1;
                     if (cur_flags != 8'h00)
                        close_message(tcv_pkg::ST_FLAGS);
                  end
                  3'd3: begin
                     cur_vlen  = {8'h00, b};
                     field_pos = field_pos + 1;
                  end
                  default: begin
                     cur_vlen[15:8] = b;
                     if (32'(cur_vlen) > msg_len - byte_pos)
                        close_message(tcv_pkg::ST_TRUNC);
                     else begin
                        // capture switch is read live
                        if (cfg_capture)
                           push_result(1'b0, tcv_pkg::ST_OK, '0, '0, cur_id, byte_pos,
                                       cur_vlen);
                        seen_cnt = seen_cnt + 1;
                        prev_id  = cur_id;
                        if (cur_vlen == 16'h0000)
                           advance_entry();
                        else begin
                           value_left  = cur_vlen;
                           parse_phase = tcv_pkg::PH_VALUE;
                        end
                     end
                  end
               endcase
            end
            default: begin
               value_left = value_left - 1;
               if (value_left == 16'h0000)
                  advance_entry();
            end
         endcase
      end
      if (step_results.size() != 0)
         step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i])
         expected_results.push_back(step_results[i]);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_begin(input logic [31:0] len);
      msg_item_type it;
      it.kind      = tcv_pkg::IK_BEGIN;
      it.total_len = len;
      it.data_byte = 8'($urandom);   // unused on a begin, kept random
      item_backlog.push_back(it);
   endtask

   task automatic add_byte(input logic [7:0] b);
      msg_item_type it;
      it.kind      = tcv_pkg::IK_DATA;
      it.total_len = $urandom;       // unused on data, kept random
      it.data_byte = b;
      item_backlog.push_back(it);
   endtask

   // Build one message against the current settings; about half go out
   // clean, the rest carry one flaw (bit flip, wrong length, cut feed, bad
   // id, flags, trailing bytes, junk count, noise in front).
   task automatic queue_message();
      logic [7:0]  body [$];
      logic [7:0]  mk;
      logic [15:0] id, prev, vlen;
      logic [31:0] len;
      int          flaw, n_ent, step, cut, sent;
      flaw = $urandom_range(0, 19);
      for (int i = 0; i < tcv_pkg::MAGIC_BYTES; i++)
         body.push_back(MAGIC_REF[8*i +: 8]);
      body.push_back(cfg_version);
      if (cfg_kind_low <= cfg_kind_high) begin
         mk = 8'($urandom_range(cfg_kind_high, cfg_kind_low));
         if (cfg_critical >= cfg_kind_low && cfg_critical <= cfg_kind_high &&
             $urandom_range(0, 3) == 0)
            mk = cfg_critical;
      end else
         mk = 8'($urandom);
      body.push_back(mk);
      n_ent = $urandom_range(0, 4);
      if (cfg_capture && cfg_capacity < 8 && $urandom_range(0, 7) == 0)
         n_ent = cfg_capacity + 1;
      body.push_back(8'(n_ent));
      body.push_back(8'h00);
      // critical ids live above the top bit; some plain runs sit near the top
      if (mk == cfg_critical) begin
         prev = tcv_pkg::ID_TOP_MASK;
         step = 200;
      end else if ($urandom_range(0, 3) == 0) begin
         prev = 16'hff00;
         step = 30;
      end else begin
         prev = 16'h0000;
         step = 200;
      end
      for (int i = 0; i < n_ent; i++) begin
         id = prev + 16'($urandom_range(1, step));
         if (flaw == 6 && i == 0)
            id = 16'h0000;
         if (flaw == 7 && i == 1)
            id = $urandom_range(0, 1) ? prev : prev - 16'd1;
         if (flaw == 8 && i == 0)
            id = $urandom_range(0, 1) ? tcv_pkg::ID_TOP_MASK : (id & tcv_pkg::ID_REST_MASK);
         vlen = 16'($urandom_range(0, 5));
         body.push_back(id[7:0]);
         body.push_back(id[15:8]);
         body.push_back((flaw == 9 && i == n_ent - 1) ? 8'(1 << $urandom_range(0, 7)) : 8'h00);
         body.push_back(vlen[7:0]);
         body.push_back(vlen[15:8]);
         for (int k = 0; k < vlen; k++)
            body.push_back(8'($urandom));
         prev = id;
      end
      if (flaw == 10)
         repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      len  = body.size();
      sent = body.size();
      case (flaw)
         0: begin
            cut       = $urandom_range(0, body.size() - 1);
            body[cut] = body[cut] ^ 8'(1 << $urandom_range(0, 7));
         end
         1: len  = $urandom_range(0, body.size() - 1);
         2: len  = body.size() + $urandom_range(1, 8);
         3: sent = $urandom_range(0, body.size() - 1);  // next begin drops it
         4: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
         5: begin
            body[tcv_pkg::MAGIC_BYTES + 2] = 8'($urandom);
            body[tcv_pkg::MAGIC_BYTES + 3] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                         : 8'h00;
         end
         default: ;
      endcase
      add_begin(len);
      for (int i = 0; i < sent; i++)
         add_byte(body[i]);
   endtask

   // ------------------------------------------------------------------------
   // Configuration writes (block idle only); shadow follows each write.
   // Upper data bits carry junk, the block keeps only the register width.
   // ------------------------------------------------------------------------
   task automatic csr_write(input tcv_pkg::csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tcv_pkg::CSR_EXPECTED_VERSION: cfg_version   = val[7:0];
         tcv_pkg::CSR_KIND_LOW:         cfg_kind_low  = val[7:0];
         tcv_pkg::CSR_KIND_HIGH:        cfg_kind_high = val[7:0];
         tcv_pkg::CSR_CRITICAL_KIND:    cfg_critical  = val[7:0];
         tcv_pkg::CSR_CAPTURE_ENABLE:   cfg_capture   = val[0];
         default:                       cfg_capacity  = val;
      endcase
   endtask

   task automatic load_settings(input logic [7:0] v, input logic [7:0] kl,
                                input logic [7:0] kh, input logic [7:0] crit,
                                input logic en, input logic [15:0] cap);
      csr_write(tcv_pkg::CSR_EXPECTED_VERSION, {8'($urandom), v});
      csr_write(tcv_pkg::CSR_KIND_LOW,         {8'($urandom), kl});
      csr_write(tcv_pkg::CSR_KIND_HIGH,        {8'($urandom), kh});
      csr_write(tcv_pkg::CSR_CRITICAL_KIND,    {8'($urandom), crit});
      csr_write(tcv_pkg::CSR_CAPTURE_ENABLE,   {15'($urandom), en});
      csr_write(tcv_pkg::CSR_ENTRY_CAPACITY,   cap);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // all offered, all results back, then let the parse pipeline settle
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (item_backlog.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_req
      msg_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         // slot free: the last transfer (if any) went at this edge
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (item_backlog.size() != 0) begin
            nxt = item_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.kind;
            req_tdata  <= {nxt.data_byte, nxt.total_len};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else
               burst_left <= burst_left - 1;
         end else
            req_tvalid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: switches between always ready, coin-toss and
   // mostly stalled, each mode held for a random stretch
   // ------------------------------------------------------------------------
   int rx_mode      = 0;
   int rx_mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         rx_mode      <= 0;
         rx_mode_left <= 0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(32, 300);
         end else
            rx_mode_left <= rx_mode_left - 1;
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check the result transfer of this edge first, then feed the
   // request transfer of this edge to the model, so the order is fixed
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      tcv_pkg::result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b tlast %0b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("is_final",     want.is_final,     rsp_tuser);
               check_field("status",       want.status,       rsp_tdata[3:0]);
               check_field("message_kind", want.message_kind, rsp_tdata[11:4]);
               check_field("num_entries",  want.num_entries,  rsp_tdata[27:12]);
               check_field("entry_id",     want.entry_id,     rsp_tdata[43:28]);
               check_field("value_offset", want.value_offset, rsp_tdata[75:44]);
               check_field("value_length", want.value_length, rsp_tdata[91:76]);
               check_field("last",         want.last,         rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            predict_item(tcv_pkg::in_kind_type'(req_tuser), req_tdata[31:0],
                         req_tdata[39:32]);
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, directed run on reset settings, then random phases
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0]  v, kl, kh, crit;
      logic        en;
      logic [15:0] cap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      add_byte(8'hff);                  // data before any begin: swallowed
      add_begin(32'd0);                 // shortest length: truncated at once
      add_begin(tcv_pkg::HDR_LEN - 1);  // one short of a header: truncated
      add_byte(8'h00);                  // after a final status: swallowed
      add_begin(32'hffff_ffff);         // huge length, dropped by the next begin
      add_byte(MAGIC_REF[7:0]);
      add_byte(MAGIC_REF[15:8]);
      add_begin(tcv_pkg::HDR_LEN);      // bare header, kind at upper bound, no entries
      for (int i = 0; i < tcv_pkg::MAGIC_BYTES; i++)
         add_byte(MAGIC_REF[8*i +: 8]);
      add_byte(tcv_pkg::RST_EXPECTED_VERSION);
      add_byte(tcv_pkg::RST_KIND_HIGH);
      add_byte(8'h00);
      add_byte(8'h00);
      add_begin(32'd20);                // bad first magic byte
      add_byte(8'h00);
      add_byte(8'h55);                  // after the magic failure: swallowed
      wait_quiet();

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            case (p)
               1: begin   // every kind legal, kind 0 critical, no room for entries
                  v = 8'h00; kl = 8'h00; kh = 8'hff; crit = 8'h00; en = 1'b1; cap = 16'h0000;
               end
               2: begin   // only kind 255, always critical, validate only
                  v = 8'hff; kl = 8'hff; kh = 8'hff; crit = 8'hff; en = 1'b0; cap = 16'hffff;
               end
               3: begin
                  v = 8'($urandom); kl = 8'h00; kh = 8'hff; crit = 8'($urandom);
                  en = 1'b1; cap = 16'hffff;
               end
               4: begin   // empty kind window: every header fails on kind
                  v = 8'($urandom); kl = 8'($urandom_range(129, 255));
                  kh = 8'($urandom_range(0, 128)); crit = 8'($urandom);
                  en = 1'($urandom_range(0, 1)); cap = 16'($urandom_range(0, 8));
               end
               default: begin
                  v = 8'($urandom); kl = 8'($urandom_range(0, 200));
                  kh = kl + 8'($urandom_range(0, 55)); crit = 8'($urandom_range(kh, kl));
                  en = 1'($urandom_range(0, 1)); cap = 16'($urandom_range(0, 8));
               end
            endcase
            load_settings(v, kl, kh, crit, en, cap);
            @(negedge clock);
         end
         while (item_backlog.size() < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 11) == 0) begin
               add_begin($urandom);     // stray begin with any length
               repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
            end
            queue_message();
         end
         add_begin(32'd0);              // leave the parser idle for the next writes
         wait_quiet();
      end

      if (mismatches == 0 && expected_results.size() == 0)
         $display("tlv_context_validator_top verification clean");
      else
         $display("tlv_context_validator_top verification failed");
      $finish;
   end

endmodule
